// ===== hdl/bbwq_pkg.sv =====
package bbwq_pkg;

  localparam int BUF_DEPTH  = 8;
  localparam int PARK_DEPTH = 16;
  localparam int DATA_W     = 8;
  localparam int CONS_W     = 8;

  localparam int BUF_AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W  = $clog2(BUF_DEPTH + 1);
  localparam int PARK_AW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;
  localparam int PCNT_W  = $clog2(PARK_DEPTH + 1);

  localparam logic [CONS_W-1:0] CONS_MAX = {CONS_W{1'b1}};

  typedef enum logic [2:0] {
    EV_STORED   = 3'd0,
    EV_PARKED   = 3'd1,
    EV_HANDED   = 3'd2,
    EV_CONSUMED = 3'd3,
    EV_CBLOCK   = 3'd4,
    EV_DROPPED  = 3'd5
  } ev_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } st_t;

endpackage

// ===== hdl/bbwq_req_if.sv =====
interface bbwq_req_if import bbwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== hdl/bbwq_res_if.sv =====
interface bbwq_res_if import bbwq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic               data_valid;
  logic [DATA_W-1:0]  data_out;
  logic               producer_released;
  logic [PCNT_W-1:0]  producers_waiting;
  logic [CONS_W-1:0]  consumers_waiting;
  logic [FILL_W-1:0]  fill_count;
  logic [BUF_AW-1:0]  write_index;
  logic [BUF_AW-1:0]  read_index;

  modport source (
    output valid, output event_res, output data_valid, output data_out,
    output producer_released, output producers_waiting, output consumers_waiting,
    output fill_count, output write_index, output read_index, input ready
  );
  modport sink (
    input valid, input event_res, input data_valid, input data_out,
    input producer_released, input producers_waiting, input consumers_waiting,
    input fill_count, input write_index, input read_index, output ready
  );
endinterface

// ===== hdl/bbwq_ram.sv =====
module bbwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bounded_buffer_with_wait_queues.sv =====
// Each accepted item is captured, then handled in ST_EXEC, which registers its result.
// A new item is not taken until ST_EXEC returns to ST_IDLE; each item does a read of both RAMs
// (buffer slot at the read pointer, park slot at its head), then at most one write back.
// A pending result does not block the next item once the sink takes it.
// Reset (rst, synchronous): state, pointers, counts and the result valid flag clear;
// RAM contents are not cleared and no clearing pass is run.
module bounded_buffer_with_wait_queues import bbwq_pkg::*; (
  input logic      clk,
  input logic      rst,
  bbwq_req_if.sink req,
  bbwq_res_if.source res
);

  st_t state, state_next;

  logic              kind;
  logic [DATA_W-1:0] value;

  logic [FILL_W-1:0]  fill_level, fill_level_next;
  logic [BUF_AW-1:0]  write_slot, write_slot_next;
  logic [BUF_AW-1:0]  read_slot, read_slot_next;
  logic [PARK_AW-1:0] parked_head, parked_head_next;
  logic [PCNT_W-1:0]  parked_count, parked_count_next;
  logic [CONS_W-1:0]  blocked_consumers, blocked_consumers_next;

  logic              res_valid, res_valid_next;
  ev_t               ev, ev_next;
  logic              dvalid, dvalid_next;
  logic [DATA_W-1:0] dout, dout_next;
  logic              released, released_next;

  logic               buf_we;
  logic [DATA_W-1:0]  buf_wdata;
  logic [DATA_W-1:0]  buf_rdata;
  logic               park_we;
  logic [PARK_AW-1:0] park_waddr;
  logic [DATA_W-1:0]  park_rdata;
  logic [PARK_AW:0]   park_sum;
  logic [FILL_W-1:0]  fill_mid;
  logic [BUF_AW-1:0]  wr_inc;
  logic [BUF_AW-1:0]  rd_inc;
  logic               accept;

  bbwq_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (write_slot),
    .wdata (buf_wdata),
    .raddr (read_slot),
    .rdata (buf_rdata)
  );

  bbwq_ram #(.WIDTH(DATA_W), .DEPTH(PARK_DEPTH)) u_park_ram (
    .clk   (clk),
    .we    (park_we),
    .waddr (park_waddr),
    .wdata (value),
    .raddr (parked_head),
    .rdata (park_rdata)
  );

  assign req.ready = (state == ST_IDLE) && (!res_valid || res.ready);
  assign accept    = req.valid && req.ready;

  assign wr_inc = (write_slot == BUF_AW'(BUF_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign rd_inc = (read_slot == BUF_AW'(BUF_DEPTH - 1)) ? '0 : read_slot + 1'b1;

  assign park_sum   = {1'b0, parked_head} + (PARK_AW + 1)'(parked_count);
  assign park_waddr = (park_sum >= (PARK_AW + 1)'(PARK_DEPTH)) ?
                      PARK_AW'(park_sum - (PARK_AW + 1)'(PARK_DEPTH)) :
                      PARK_AW'(park_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      fill_level        <= '0;
      write_slot        <= '0;
      read_slot         <= '0;
      parked_head       <= '0;
      parked_count      <= '0;
      blocked_consumers <= '0;
      res_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      fill_level        <= fill_level_next;
      write_slot        <= write_slot_next;
      read_slot         <= read_slot_next;
      parked_head       <= parked_head_next;
      parked_count      <= parked_count_next;
      blocked_consumers <= blocked_consumers_next;
      res_valid         <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req.kind;
      value <= req.value;
    end
    ev       <= ev_next;
    dvalid   <= dvalid_next;
    dout     <= dout_next;
    released <= released_next;
  end

  always_comb begin
    state_next             = state;
    fill_level_next        = fill_level;
    write_slot_next        = write_slot;
    read_slot_next         = read_slot;
    parked_head_next       = parked_head;
    parked_count_next      = parked_count;
    blocked_consumers_next = blocked_consumers;
    res_valid_next         = res_valid && !res.ready;
    ev_next                = ev;
    dvalid_next            = dvalid;
    dout_next              = dout;
    released_next          = released;
    buf_we                 = 1'b0;
    buf_wdata              = value;
    park_we                = 1'b0;
    fill_mid               = fill_level;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next     = ST_IDLE;
        res_valid_next = 1'b1;
        dvalid_next    = 1'b0;
        dout_next      = '0;
        released_next  = 1'b0;
        if (!kind) begin
          if (blocked_consumers != '0) begin
            blocked_consumers_next = blocked_consumers - 1'b1;
            ev_next     = EV_HANDED;
            dvalid_next = 1'b1;
            dout_next   = value;
            if (fill_level < FILL_W'(BUF_DEPTH)) begin
              buf_we          = 1'b1;
              write_slot_next = wr_inc;
              read_slot_next  = rd_inc;
            end
          end else if (fill_level < FILL_W'(BUF_DEPTH)) begin
            buf_we          = 1'b1;
            write_slot_next = wr_inc;
            fill_level_next = fill_level + 1'b1;
            ev_next         = EV_STORED;
          end else if (parked_count < PCNT_W'(PARK_DEPTH)) begin
            park_we           = 1'b1;
            parked_count_next = parked_count + 1'b1;
            ev_next           = EV_PARKED;
          end else begin
            ev_next = EV_DROPPED;
          end
        end else begin
          if (fill_level == '0) begin
            if (blocked_consumers != CONS_MAX) begin
              blocked_consumers_next = blocked_consumers + 1'b1;
            end
            ev_next = EV_CBLOCK;
          end else begin
            dout_next      = buf_rdata;
            dvalid_next    = 1'b1;
            read_slot_next = rd_inc;
            fill_mid       = fill_level - 1'b1;
            ev_next        = EV_CONSUMED;
          end
          fill_level_next = fill_mid;
          if (parked_count != '0 && fill_mid < FILL_W'(BUF_DEPTH)) begin
            buf_we            = 1'b1;
            buf_wdata         = park_rdata;
            write_slot_next   = wr_inc;
            fill_level_next   = fill_mid + 1'b1;
            parked_head_next  = (parked_head == PARK_AW'(PARK_DEPTH - 1)) ?
                                '0 : parked_head + 1'b1;
            parked_count_next = parked_count - 1'b1;
            released_next     = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res.valid             = res_valid;
  assign res.event_res         = ev;
  assign res.data_valid        = dvalid;
  assign res.data_out          = dout;
  assign res.producer_released = released;
  assign res.producers_waiting = parked_count;
  assign res.consumers_waiting = blocked_consumers;
  assign res.fill_count        = fill_level;
  assign res.write_index       = write_slot;
  assign res.read_index        = read_slot;

endmodule
